/* src/pfma_pkg.sv */
`default_nettype none

package pfma_pkg;

  localparam int unsigned W            = 256;
  localparam int unsigned WIDE         = 2 * W;
  localparam int unsigned REDUCE_STEPS = 256 + 1;
  localparam int unsigned EXP_BITS     = 256;
  localparam int unsigned CNT_W        = 9;

  // The prime 2^255 - 19.
  localparam logic [W-1:0] PRIME = {1'b0, {250{1'b1}}, 5'b01101};

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_POW = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] a_limb_0;
    logic [63:0] a_limb_1;
    logic [63:0] a_limb_2;
    logic [62:0] a_limb_3;
    logic [63:0] b_limb_0;
    logic [63:0] b_limb_1;
    logic [63:0] b_limb_2;
    logic [63:0] b_limb_3;
  } pfma_in_t;

  typedef struct packed {
    logic [63:0] r_limb_0;
    logic [63:0] r_limb_1;
    logic [63:0] r_limb_2;
    logic [63:0] r_limb_3;
  } pfma_out_t;

endpackage

`default_nettype wire

/* src/pfma_addsub.sv */
`default_nettype none

module pfma_addsub
  import pfma_pkg::*;
(
  input  wire logic [WIDE-1:0] x,
  input  wire logic [WIDE-1:0] y,
  input  wire logic            sub,
  output logic      [WIDE:0]   sum
);

  logic [WIDE-1:0] y_eff;

  // Subtraction is x + ~y + 1; the top bit is the carry, set when x >= y.
  assign y_eff = sub ? ~y : y;
  assign sum   = {1'b0, x} + {1'b0, y_eff} + {{WIDE{1'b0}}, sub};

endmodule

`default_nettype wire

/* src/prime_field_modular_alu.sv */
`default_nettype none
// Field arithmetic unit modulo p = 2^255 - 19.
// Input channel: drive in_data and pulse start while busy is low; the
// transaction is taken at that edge and busy rises on the next cycle.
// Actions: add, subtract, multiply and exponentiate (A^B, B as a 256-bit
// exponent scanned from its least significant bit).
// Result channel: out_valid is high for exactly one cycle with out_data;
// the receiver cannot stall, so it must capture the result in that cycle.
// Add sums A and B, then subtracts p when the sum is at least p. Subtract
// gives A - B when A >= B, else forms A + p and then subtracts B.
// Exponentiate runs 256 to 512 modular products, each a multiply as below
// followed by a check state, plus one final check. One transaction is in
// work at a time; busy drops in the cycle that shows the result, so the
// next start may come in that cycle.
// All arithmetic goes through one shared 512-bit adder/subtractor: a multiply is
// 256 shift-and-add steps followed by 257 compare-and-subtract steps.
// Reset (rst_n low, synchronous) returns to idle and drops any transaction
// in work; no result is produced for it.

module prime_field_modular_alu
  import pfma_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire pfma_in_t  in_data,
  output logic           out_valid,
  output pfma_out_t      out_data
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_ADD1   = 9'b000000010,
    ST_ADD2   = 9'b000000100,
    ST_SUB1   = 9'b000001000,
    ST_SUB2   = 9'b000010000,
    ST_SUB3   = 9'b000100000,
    ST_MULP   = 9'b001000000,
    ST_MULR   = 9'b010000000,
    ST_POWCHK = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic            done_r, done_nxt;
  logic [1:0]      act_r, act_nxt;
  logic [W-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [WIDE-1:0] acc_r, acc_nxt, sh_r, sh_nxt;
  logic [W-1:0]    mx_r, mx_nxt, my_r, my_nxt;
  logic [W-1:0]    res_r, res_nxt, run_r, run_nxt, r_r, r_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, ebit_r, ebit_nxt;
  logic            sq_r, sq_nxt;

  logic [WIDE-1:0] ux, uy;
  logic            usub;
  logic [WIDE:0]   usum;
  logic            carry;
  logic [WIDE-1:0] red_val;
  logic [W-1:0]    zero_w;

  assign zero_w = '0;

  pfma_addsub u_addsub (
    .x   (ux),
    .y   (uy),
    .sub (usub),
    .sum (usum)
  );

  assign carry   = usum[WIDE];
  assign red_val = carry ? usum[WIDE-1:0] : acc_r;

  // Operand selection for the shared adder.
  always_comb begin
    ux   = '0;
    uy   = '0;
    usub = 1'b0;
    unique case (state_r)
      ST_ADD1: begin
        ux = {zero_w, a_r};
        uy = {zero_w, b_r};
      end
      ST_ADD2: begin
        ux   = {zero_w, acc_r[W-1:0]};
        uy   = {zero_w, PRIME};
        usub = 1'b1;
      end
      ST_SUB1: begin
        ux   = {zero_w, a_r};
        uy   = {zero_w, b_r};
        usub = 1'b1;
      end
      ST_SUB2: begin
        ux = {zero_w, a_r};
        uy = {zero_w, PRIME};
      end
      ST_SUB3: begin
        ux   = {zero_w, acc_r[W-1:0]};
        uy   = {zero_w, b_r};
        usub = 1'b1;
      end
      ST_MULP: begin
        ux = {acc_r[WIDE-2:0], 1'b0};
        uy = my_r[W-1] ? {zero_w, mx_r} : '0;
      end
      ST_MULR: begin
        ux   = acc_r;
        uy   = sh_r;
        usub = 1'b1;
      end
      default: begin
        ux = '0;
      end
    endcase
  end

  // Sequencer and next values of the working registers.
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    act_nxt   = act_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    res_nxt   = res_r;
    run_nxt   = run_r;
    r_nxt     = r_r;
    cnt_nxt   = cnt_r;
    ebit_nxt  = ebit_r;
    sq_nxt    = sq_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt  = in_data.action;
          a_nxt    = {1'b0, in_data.a_limb_3, in_data.a_limb_2,
                      in_data.a_limb_1, in_data.a_limb_0};
          b_nxt    = {in_data.b_limb_3, in_data.b_limb_2,
                      in_data.b_limb_1, in_data.b_limb_0};
          acc_nxt  = '0;
          cnt_nxt  = CNT_W'(W - 1);
          mx_nxt   = a_nxt;
          my_nxt   = b_nxt;
          res_nxt  = W'(1);
          run_nxt  = a_nxt;
          ebit_nxt = '0;
          sq_nxt   = 1'b0;
          unique case (in_data.action)
            ACT_ADD: state_nxt = ST_ADD1;
            ACT_SUB: state_nxt = ST_SUB1;
            ACT_MUL: state_nxt = ST_MULP;
            ACT_POW: state_nxt = ST_POWCHK;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD1: begin
        acc_nxt   = {zero_w, usum[W-1:0]};
        state_nxt = ST_ADD2;
      end
      ST_ADD2: begin
        r_nxt     = carry ? usum[W-1:0] : acc_r[W-1:0];
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SUB1: begin
        if (carry) begin
          r_nxt     = usum[W-1:0];
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SUB2;
        end
      end
      ST_SUB2: begin
        acc_nxt   = {zero_w, usum[W-1:0]};
        state_nxt = ST_SUB3;
      end
      ST_SUB3: begin
        r_nxt     = usum[W-1:0];
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      // Product, most significant multiplier bit first.
      ST_MULP: begin
        acc_nxt = usum[WIDE-1:0];
        my_nxt  = {my_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          sh_nxt    = {PRIME, zero_w};
          cnt_nxt   = CNT_W'(REDUCE_STEPS - 1);
          state_nxt = ST_MULR;
        end
      end
      // Reduction: subtract p shifted from 256 places down to 0.
      ST_MULR: begin
        acc_nxt = red_val;
        sh_nxt  = {1'b0, sh_r[WIDE-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (act_r == ACT_POW) begin
            if (sq_r) begin
              run_nxt  = red_val[W-1:0];
              ebit_nxt = ebit_r + 1'b1;
              sq_nxt   = 1'b0;
            end else begin
              res_nxt = red_val[W-1:0];
              sq_nxt  = 1'b1;
            end
            state_nxt = ST_POWCHK;
          end else begin
            r_nxt     = red_val[W-1:0];
            done_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      // Pick the next product of the exponentiation, or finish.
      ST_POWCHK: begin
        acc_nxt = '0;
        cnt_nxt = CNT_W'(W - 1);
        if (ebit_r == CNT_W'(EXP_BITS)) begin
          r_nxt     = res_r;
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!sq_r && b_r[ebit_r[CNT_W-2:0]]) begin
          mx_nxt    = res_r;
          my_nxt    = run_r;
          state_nxt = ST_MULP;
        end else begin
          mx_nxt    = run_r;
          my_nxt    = run_r;
          sq_nxt    = 1'b1;
          state_nxt = ST_MULP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    sh_r   <= sh_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    res_r  <= res_nxt;
    run_r  <= run_nxt;
    r_r    <= r_nxt;
    cnt_r  <= cnt_nxt;
    ebit_r <= ebit_nxt;
    sq_r   <= sq_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = done_r;
  assign out_data  = '{r_limb_0: r_r[63:0],    r_limb_1: r_r[127:64],
                       r_limb_2: r_r[191:128], r_limb_3: r_r[255:192]};

endmodule

`default_nettype wire

/* src/pfma_checker.sv */
`default_nettype none

module pfma_checker
  import pfma_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid
);

  // A transaction that is taken makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // A result only follows a cycle of work.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

  // The block is free again in the cycle that shows the result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while the result is shown");

  // Each transaction gives a single-cycle strobe.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Reset leaves the block idle with no result.
  assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind prime_field_modular_alu pfma_checker u_pfma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top
  import pfma_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [WIDE-1:0] PRIME_WIDE = {{W{1'b0}}, PRIME};

  // Tracks expected field results and compares them with the block's output.
  class field_scoreboard;
    pfma_out_t pending_results[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // Modular product, fully reduced below the prime.
    function logic [W-1:0] mod_product(logic [W-1:0] x, logic [W-1:0] y);
      logic [WIDE-1:0] prod;
      prod = {{W{1'b0}}, x} * {{W{1'b0}}, y};
      prod = prod % PRIME_WIDE;
      return prod[W-1:0];
    endfunction

    // Computes the field result for one command.
    function logic [W-1:0] field_result(pfma_in_t cmd);
      logic [W-1:0] a_val;
      logic [W-1:0] b_val;
      logic [W-1:0] sum;
      logic [W-1:0] power;
      logic [W-1:0] acc;
      a_val = {1'b0, cmd.a_limb_3, cmd.a_limb_2, cmd.a_limb_1, cmd.a_limb_0};
      b_val = {cmd.b_limb_3, cmd.b_limb_2, cmd.b_limb_1, cmd.b_limb_0};
      case (action_t'(cmd.action))
        ACT_ADD: begin
          sum = a_val + b_val;
          if (sum >= PRIME) sum = sum - PRIME;
          return sum;
        end
        ACT_SUB: begin
          if (a_val >= b_val) return a_val - b_val;
          return a_val + PRIME - b_val;
        end
        ACT_MUL: return mod_product(a_val, b_val);
        default: begin
          // Square-and-multiply from the least significant exponent bit.
          power = a_val;
          acc = 1;
          for (int i = 0; i < EXP_BITS; i++) begin
            if (b_val[i]) acc = mod_product(acc, power);
            power = mod_product(power, power);
          end
          return acc;
        end
      endcase
    endfunction

    // Notes an accepted command transaction.
    function void note_command(pfma_in_t cmd);
      logic [W-1:0] r;
      pfma_out_t res;
      r = field_result(cmd);
      res.r_limb_0 = r[63:0];
      res.r_limb_1 = r[127:64];
      res.r_limb_2 = r[191:128];
      res.r_limb_3 = r[255:192];
      pending_results.push_back(res);
    endfunction

    // Checks one result transaction against the oldest expectation.
    function void check_result(pfma_out_t got);
      pfma_out_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failures++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.r_limb_0 !== exp_res.r_limb_0)
        $display("%0t: r_limb_0 expected %h actual %h", $time, exp_res.r_limb_0, got.r_limb_0);
      if (got.r_limb_1 !== exp_res.r_limb_1)
        $display("%0t: r_limb_1 expected %h actual %h", $time, exp_res.r_limb_1, got.r_limb_1);
      if (got.r_limb_2 !== exp_res.r_limb_2)
        $display("%0t: r_limb_2 expected %h actual %h", $time, exp_res.r_limb_2, got.r_limb_2);
      if (got.r_limb_3 !== exp_res.r_limb_3)
        $display("%0t: r_limb_3 expected %h actual %h", $time, exp_res.r_limb_3, got.r_limb_3);
      if (got !== exp_res) failures++;
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  pfma_in_t  in_data;
  logic      out_valid;
  pfma_out_t out_data;

  field_scoreboard sb;
  bit no_gaps;

  prime_field_modular_alu u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result monitor: every strobe is a transaction that must be taken now.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic pfma_in_t make_cmd(action_t act, logic [254:0] a_val,
                                        logic [255:0] b_val);
    pfma_in_t cmd;
    cmd.action   = act;
    cmd.a_limb_0 = a_val[63:0];
    cmd.a_limb_1 = a_val[127:64];
    cmd.a_limb_2 = a_val[191:128];
    cmd.a_limb_3 = a_val[254:192];
    cmd.b_limb_0 = b_val[63:0];
    cmd.b_limb_1 = b_val[127:64];
    cmd.b_limb_2 = b_val[191:128];
    cmd.b_limb_3 = b_val[255:192];
    return cmd;
  endfunction

  // Random 256-bit operand, biased toward zero, small values, the prime and the all-ones maximum.
  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(7))
      0: v = v[7:0];
      1: v = PRIME - v[5:0];
      2: v = PRIME + v[4:0];
      3: v = {256{1'b1}} - v[3:0];
      default: ;
    endcase
    return v;
  endfunction

  // Sends one command transaction, with an occasional idle cycle before it.
  task automatic send_command(pfma_in_t cmd);
    if (!no_gaps && $urandom_range(99) < 7) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_command(cmd);
    @(negedge clk);
  endtask

  initial begin
    logic [255:0] ones;
    logic [255:0] pm1;
    logic [255:0] a_rand;
    int unsigned  act_pick;
    int unsigned  pows_left;
    int unsigned  wait_cycles;
    action_t      act;

    sb      = new();
    ones    = {256{1'b1}};
    pm1     = PRIME - 1;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cases: extremes, wraparound and operands outside the field.
    send_command(make_cmd(ACT_ADD, '0, '0));
    send_command(make_cmd(ACT_ADD, pm1[254:0], 256'd1));
    send_command(make_cmd(ACT_ADD, ones[254:0], ones));
    send_command(make_cmd(ACT_ADD, PRIME[254:0] + 255'd3, 256'd0));
    send_command(make_cmd(ACT_SUB, '0, 256'd1));
    send_command(make_cmd(ACT_SUB, 255'd5, 256'd5));
    send_command(make_cmd(ACT_SUB, ones[254:0], ones));
    send_command(make_cmd(ACT_SUB, ones[254:0], 256'd0));
    send_command(make_cmd(ACT_SUB, '0, ones));
    send_command(make_cmd(ACT_MUL, ones[254:0], {1'b0, ones[254:0]}));
    send_command(make_cmd(ACT_MUL, pm1[254:0], pm1));
    send_command(make_cmd(ACT_MUL, '0, pm1));
    send_command(make_cmd(ACT_MUL, 255'd1, PRIME));
    send_command(make_cmd(ACT_MUL, ones[254:0], ones));
    send_command(make_cmd(ACT_POW, '0, '0));
    send_command(make_cmd(ACT_POW, ones[254:0], 256'd1));
    send_command(make_cmd(ACT_POW, 255'd2, ones));

    // Random part: mostly add, subtract and multiply; a couple of slow powers.
    pows_left = 2;
    for (int n = 0; n < 100; n++) begin
      no_gaps  = (n >= 40 && n < 70);
      act_pick = $urandom_range(99);
      if (act_pick < 30) act = ACT_ADD;
      else if (act_pick < 60) act = ACT_SUB;
      else act = ACT_MUL;
      if (pows_left > 0 && (n == 25 || n == 80)) begin
        act = ACT_POW;
        pows_left--;
      end
      a_rand = rand_operand();
      send_command(make_cmd(act, a_rand[254:0], rand_operand()));
    end
    start <= 1'b0;

    // Drain outstanding results, then let the clock run on before checking.
    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 2000000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);

    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
